/* sv/ttr_pkg.sv */
// Shared types, constants and codes for the textured triangle rasteriser.
// No dependencies; every other file refers to this package by scoped name.
package ttr_pkg;

  // Fixed field widths
  localparam int VW = 19;   // vertex coordinate
  localparam int EW = 32;   // edge and span accumulators
  localparam int IW = 22;   // pixel and texel indices
  localparam int RGW = 12;  // configuration registers

  // Defaults for the top level parameters
  localparam int DEF_MAX_DIM = 2048;
  localparam int DEF_FRAC_BITS = 8;

  // Register reset values
  localparam logic [RGW-1:0] TEX_W_RESET = 12'd256;
  localparam logic [RGW-1:0] TGT_W_RESET = 12'd640;

  typedef struct packed {
    logic [VW-1:0] x;
    logic [VW-1:0] y;
    logic [VW-1:0] u;
    logic [VW-1:0] v;
  } vert_t;

  // Rasterisation phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RUN1,
    PH_RUN2,
    PH_SPAN1,
    PH_SPAN2
  } phase_e;

  // Sequencer state
  typedef enum logic [2:0] {
    S_IN,
    S_SORT,
    S_DSTART,
    S_DWAIT,
    S_TICK,
    S_PIX,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FLAT = 2'd1,
    STATUS_BUSY = 2'd2
  } status_e;

  typedef enum logic {
    REG_TEXTURE_WIDTH = 1'b0,
    REG_TARGET_WIDTH  = 1'b1
  } reg_e;

endpackage

/* sv/textured_triangle_rasterizer_core.sv */
// Textured triangle rasteriser: one result word per input word.
// A vertex load passes the input and output states; the third load adds sorting
// and nine slope divisions on the shared divider. A pixel tick passes the tick,
// pixel and output states; each new row adds walking steps and two span
// divisions. Only one word is in flight at a time. Reset (rst_ni low, async)
// empties the pipeline, sets phase idle and the width registers to 256 and 640.
module textured_triangle_rasterizer_core #(
  parameter int MAX_DIM = ttr_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = ttr_pkg::DEF_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [ttr_pkg::RGW-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic [ttr_pkg::VW-1:0]  vert_x_i,
  input  logic [ttr_pkg::VW-1:0]  vert_y_i,
  input  logic [ttr_pkg::VW-1:0]  vert_u_i,
  input  logic [ttr_pkg::VW-1:0]  vert_v_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    pixel_valid_o,
  output logic [ttr_pkg::IW-1:0]  dst_index_o,
  output logic [ttr_pkg::IW-1:0]  src_index_o,
  output logic                    done_res_o,
  output logic [1:0]              status_o
);

  localparam int RW = $clog2(MAX_DIM);
  localparam int EW = ttr_pkg::EW;
  localparam int VW = ttr_pkg::VW;
  localparam int DW = EW + 1;
  localparam int NW = DW + FRAC_BITS;
  localparam logic [EW-1:0] ONE = EW'(1) << FRAC_BITS;

  ttr_pkg::state_e  state_q, state_d;
  ttr_pkg::phase_e  phase_q, phase_d;
  ttr_pkg::status_e res_status_q, res_status_d, out_status_q;
  ttr_pkg::vert_t   vert_q [3];
  ttr_pkg::vert_t   vert_d [3];
  logic             div_start, div_done;

  logic [1:0]    vcount_q, vcount_d, e_q, e_d, c_q, c_d;
  logic          div_span_q, div_span_d;
  logic [RW-1:0] row_q, row_d;
  logic [EW-1:0] ex_q [3], eu_q [3], ev_q [3], exs_q [3], eus_q [3], evs_q [3];
  logic [EW-1:0] ex_d [3], eu_d [3], ev_d [3], exs_d [3], eus_d [3], evs_d [3];
  logic [EW-1:0] sx_q, send_q, su_q, sv_q, sus_q, svs_q;
  logic [EW-1:0] sx_d, send_d, su_d, sv_d, sus_d, svs_d;
  logic [DW-1:0] sdu_q, sdv_q, sw_q, sdu_d, sdv_d, sw_d;
  logic          res_pix_q, res_pix_d, res_done_q, res_done_d;
  logic [ttr_pkg::IW-1:0] res_dst_q, res_dst_d, res_src_q, res_src_d;
  logic          out_valid_q, out_pix_q, out_done_q;
  logic [ttr_pkg::IW-1:0] out_dst_q, out_src_q;
  logic [ttr_pkg::RGW-1:0] tex_w_q, tgt_w_q;

  logic                 in_acc;
  logic signed [NW-1:0] div_num;
  logic [DW-1:0]        div_den;
  logic [EW-1:0]        div_quot;
  logic [ttr_pkg::IW-1:0] idx_dst, idx_src;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ttr_pkg::S_IN);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= ttr_pkg::TEX_W_RESET;
      tgt_w_q <= ttr_pkg::TGT_W_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ttr_pkg::REG_TEXTURE_WIDTH: tex_w_q <= cfg_data_i;
        ttr_pkg::REG_TARGET_WIDTH:  tgt_w_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Divider operands: edge slopes during setup, span gradients otherwise
  always_comb begin
    logic [VW-1:0]     fa, ta, dy;
    logic signed [19:0] dd;
    ttr_pkg::vert_t    fv, tv;
    logic [DW-1:0]     sd;
    fv = vert_q[0];
    tv = vert_q[2];
    unique case (e_q)
      2'd1: tv = vert_q[1];
      2'd2: fv = vert_q[1];
      default: ;
    endcase
    dy = fv.y - tv.y;
    if (dy == '0) dy = VW'(ONE);
    case (c_q)
      2'd1:    begin fa = fv.u; ta = tv.u; end
      2'd2:    begin fa = fv.v; ta = tv.v; end
      default: begin fa = fv.x; ta = tv.x; end
    endcase
    dd = $signed({1'b0, fa}) - $signed({1'b0, ta});
    sd = (c_q == 2'd0) ? sdu_q : sdv_q;
    if (div_span_q) begin
      div_num = {sd, {FRAC_BITS{1'b0}}};
      div_den = sw_q;
    end else begin
      div_num = {{(NW-20-FRAC_BITS){dd[19]}}, dd, {FRAC_BITS{1'b0}}};
      div_den = DW'(dy);
    end
  end

  ttr_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  ttr_index #(.RW(RW), .FRAC_BITS(FRAC_BITS)) u_index (
    .row_i  (row_q),
    .x_i    (sx_q),
    .u_i    (su_q),
    .v_i    (sv_q),
    .tex_w_i(tex_w_q),
    .tgt_w_i(tgt_w_q),
    .dst_o  (idx_dst),
    .src_o  (idx_src)
  );

  // Sequencer: next state and datapath updates
  always_comb begin
    ttr_pkg::vert_t a, b, c, t;
    logic [EW-1:0]  ssx, sex, ssu, seu, ssv, sev, tmp, ty;
    logic [DW-1:0]  w;
    logic [1:0]     es;
    logic [EW-1:0]  rowfx;
    state_d = state_q;  phase_d = phase_q;  vcount_d = vcount_q;
    e_d = e_q;  c_d = c_q;  div_span_d = div_span_q;  row_d = row_q;
    vert_d = vert_q;
    ex_d = ex_q;  eu_d = eu_q;  ev_d = ev_q;
    exs_d = exs_q;  eus_d = eus_q;  evs_d = evs_q;
    sx_d = sx_q;  send_d = send_q;  su_d = su_q;  sv_d = sv_q;
    sus_d = sus_q;  svs_d = svs_q;  sdu_d = sdu_q;  sdv_d = sdv_q;  sw_d = sw_q;
    res_pix_d = res_pix_q;  res_done_d = res_done_q;  res_status_d = res_status_q;
    res_dst_d = res_dst_q;  res_src_d = res_src_q;
    div_start = 1'b0;
    rowfx = EW'({row_q, {FRAC_BITS{1'b0}}});
    // Upper half uses the top-middle edge, lower half the middle-bottom edge
    es = (phase_q == ttr_pkg::PH_RUN1 || phase_q == ttr_pkg::PH_SPAN1) ? 2'd1 : 2'd2;

    // Sorted by y, largest first
    a = vert_q[0];  b = vert_q[1];  c = vert_q[2];
    if (a.y < b.y) begin t = a; a = b; b = t; end
    if (b.y < c.y) begin t = b; b = c; c = t; end
    if (a.y < b.y) begin t = a; a = b; b = t; end
    ty = EW'(a.y) >> FRAC_BITS;

    // Span bounds between the long edge and edge es
    ssx = ex_q[0];  ssu = eu_q[0];  ssv = ev_q[0];
    sex = ex_q[es]; seu = eu_q[es]; sev = ev_q[es];
    if ($signed(sex) < $signed(ssx)) begin
      tmp = sex; sex = ssx; ssx = tmp;
      tmp = seu; seu = ssu; ssu = tmp;
      tmp = sev; sev = ssv; ssv = tmp;
    end
    w = {sex[EW-1], sex} - {ssx[EW-1], ssx};
    if (w == '0) w = DW'(ONE);

    res_pix_d = 1'b0;
    unique case (state_q)
      ttr_pkg::S_IN: begin
        if (in_acc) begin
          res_pix_d = 1'b0;  res_done_d = 1'b0;
          res_status_d = ttr_pkg::STATUS_OK;
          res_dst_d = '0;  res_src_d = '0;
          state_d = ttr_pkg::S_OUT;
          if (!mode_i) begin
            if (phase_q != ttr_pkg::PH_IDLE) begin
              res_status_d = ttr_pkg::STATUS_BUSY;
            end else begin
              vert_d[(vcount_q == 2'd3) ? 2'd0 : vcount_q] =
                '{x: vert_x_i, y: vert_y_i, u: vert_u_i, v: vert_v_i};
              if (vcount_q == 2'd1 || vcount_q == 2'd0 || vcount_q == 2'd3) begin
                vcount_d = (vcount_q == 2'd3) ? 2'd1 : vcount_q + 2'd1;
              end else begin
                vcount_d = 2'd0;
                state_d  = ttr_pkg::S_SORT;
              end
            end
          end else if (phase_q != ttr_pkg::PH_IDLE) begin
            state_d = ttr_pkg::S_TICK;
          end
        end
      end
      ttr_pkg::S_SORT: begin
        vert_d[0] = a;  vert_d[1] = b;  vert_d[2] = c;
        if (a.y == c.y) begin
          res_done_d = 1'b1;
          res_status_d = ttr_pkg::STATUS_FLAT;
          state_d = ttr_pkg::S_OUT;
        end else begin
          row_d = (ty > EW'(MAX_DIM - 1)) ? RW'(MAX_DIM - 1) : RW'(ty);
          e_d = 2'd0;  c_d = 2'd0;  div_span_d = 1'b0;
          state_d = ttr_pkg::S_DSTART;
        end
      end
      ttr_pkg::S_DSTART: begin
        div_start = 1'b1;
        state_d = ttr_pkg::S_DWAIT;
      end
      ttr_pkg::S_DWAIT: begin
        if (div_done) begin
          if (div_span_q) begin
            if (c_q == 2'd0) begin
              sus_d = div_quot;  c_d = 2'd1;
              state_d = ttr_pkg::S_DSTART;
            end else begin
              svs_d = div_quot;
              phase_d = (e_q == 2'd1) ? ttr_pkg::PH_SPAN1 : ttr_pkg::PH_SPAN2;
              state_d = ttr_pkg::S_TICK;
            end
          end else begin
            // Edge start point and slope for one component
            case (c_q)
              2'd1: begin
                eu_d[e_q] = EW'((e_q == 2'd2) ? vert_q[1].u : vert_q[0].u);
                eus_d[e_q] = div_quot;
              end
              2'd2: begin
                ev_d[e_q] = EW'((e_q == 2'd2) ? vert_q[1].v : vert_q[0].v);
                evs_d[e_q] = div_quot;
              end
              default: begin
                ex_d[e_q] = EW'((e_q == 2'd2) ? vert_q[1].x : vert_q[0].x);
                exs_d[e_q] = div_quot;
              end
            endcase
            if (c_q == 2'd2) begin
              c_d = 2'd0;  e_d = e_q + 2'd1;
            end else begin
              c_d = c_q + 2'd1;
            end
            if (c_q == 2'd2 && e_q == 2'd2) begin
              phase_d = ttr_pkg::PH_RUN1;
              state_d = ttr_pkg::S_OUT;
            end else begin
              state_d = ttr_pkg::S_DSTART;
            end
          end
        end
      end
      ttr_pkg::S_TICK: begin
        unique case (phase_q)
          ttr_pkg::PH_SPAN1, ttr_pkg::PH_SPAN2: begin
            if ($signed(sx_q) < $signed(send_q)) begin
              state_d = ttr_pkg::S_PIX;
            end else begin
              // End of row: step the long edge and the active short edge
              ex_d[0] = ex_q[0] - exs_q[0];
              eu_d[0] = eu_q[0] - eus_q[0];
              ev_d[0] = ev_q[0] - evs_q[0];
              ex_d[es + 2'd0] = ex_q[es] - exs_q[es];
              eu_d[es + 2'd0] = eu_q[es] - eus_q[es];
              ev_d[es + 2'd0] = ev_q[es] - evs_q[es];
              row_d = row_q - RW'(1);
              phase_d = (phase_q == ttr_pkg::PH_SPAN1) ? ttr_pkg::PH_RUN1
                                                       : ttr_pkg::PH_RUN2;
            end
          end
          ttr_pkg::PH_RUN1, ttr_pkg::PH_RUN2: begin
            if (rowfx > EW'(vert_q[es].y)) begin
              sx_d = ssx;  send_d = sex;  su_d = ssu;  sv_d = ssv;
              sdu_d = {seu[EW-1], seu} - {ssu[EW-1], ssu};
              sdv_d = {sev[EW-1], sev} - {ssv[EW-1], ssv};
              sw_d = w;
              e_d = es;  c_d = 2'd0;  div_span_d = 1'b1;
              state_d = ttr_pkg::S_DSTART;
            end else if (phase_q == ttr_pkg::PH_RUN1) begin
              phase_d = ttr_pkg::PH_RUN2;
            end else begin
              phase_d = ttr_pkg::PH_IDLE;
              res_done_d = 1'b1;
              state_d = ttr_pkg::S_OUT;
            end
          end
          default: state_d = ttr_pkg::S_OUT;
        endcase
        // keep res_pix clear while walking
        res_pix_d = 1'b0;
      end
      ttr_pkg::S_PIX: begin
        res_pix_d = 1'b1;
        res_dst_d = idx_dst;
        res_src_d = idx_src;
        su_d = su_q + sus_q;
        sv_d = sv_q + svs_q;
        sx_d = sx_q + ONE;
        state_d = ttr_pkg::S_OUT;
      end
      ttr_pkg::S_OUT: begin
        res_pix_d = res_pix_q;
        if (!out_valid_q || !out_stall_i) state_d = ttr_pkg::S_IN;
      end
      default: state_d = ttr_pkg::S_IN;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ttr_pkg::S_IN;
      phase_q    <= ttr_pkg::PH_IDLE;
      vcount_q   <= '0;
      e_q        <= '0;
      c_q        <= '0;
      div_span_q <= 1'b0;
      row_q      <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      vcount_q   <= vcount_d;
      e_q        <= e_d;
      c_q        <= c_d;
      div_span_q <= div_span_d;
      row_q      <= row_d;
    end
  end

  // Edge, span and pending result registers
  always_ff @(posedge clk_i) begin
    vert_q <= vert_d;
    ex_q <= ex_d;  eu_q <= eu_d;  ev_q <= ev_d;
    exs_q <= exs_d;  eus_q <= eus_d;  evs_q <= evs_d;
    sx_q <= sx_d;  send_q <= send_d;  su_q <= su_d;  sv_q <= sv_d;
    sus_q <= sus_d;  svs_q <= svs_d;
    sdu_q <= sdu_d;  sdv_q <= sdv_d;  sw_q <= sw_d;
    res_pix_q <= res_pix_d;  res_done_q <= res_done_d;
    res_status_q <= res_status_d;
    res_dst_q <= res_dst_d;  res_src_q <= res_src_d;
  end

  // Output register: loaded from the pending result once free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ttr_pkg::S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ttr_pkg::S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_pix_q    <= res_pix_q;
      out_done_q   <= res_done_q;
      out_status_q <= res_status_q;
      out_dst_q    <= res_dst_q;
      out_src_q    <= res_src_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_valid_o = out_pix_q;
  assign dst_index_o   = out_dst_q;
  assign src_index_o   = out_src_q;
  assign done_res_o    = out_done_q;
  assign status_o      = out_status_q;

  // An accepted word always leaves the input state
  a_acc_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ttr_pkg::S_IN)
    else $error("input accepted but sequencer stayed in input state");

  // Divider completes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ttr_pkg::S_DWAIT)
    else $error("divider result with no waiting sequencer");

  // A pixel word never also reports completion
  a_pix_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_valid_o |-> !done_res_o && status_o == ttr_pkg::STATUS_OK)
    else $error("pixel word carries completion or error status");

  // A rejected triangle leaves the phase idle
  a_flat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ttr_pkg::S_SORT && vert_q[0].y == vert_q[1].y
      && vert_q[1].y == vert_q[2].y |=> phase_q == ttr_pkg::PH_IDLE)
    else $error("flat triangle started rasterising");

endmodule

/* sv/ttr_div.sv */
// Shared restoring divider, one quotient bit per cycle, signed numerator.
// Depends on ttr_pkg for the accumulator width.
module ttr_div #(
  parameter int NW = 41,
  parameter int DW = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic        [DW-1:0] den_i,
  output logic                 done_o,
  output logic [ttr_pkg::EW-1:0] quot_o
);

  localparam int CW = $clog2(NW);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_sh, diff;
  logic          qbit;

  // One trial subtraction per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[NW-1]};
    diff   = rem_sh - {1'b0, den_q};
    qbit   = ~diff[DW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      quo_q <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -quo_q[ttr_pkg::EW-1:0] : quo_q[ttr_pkg::EW-1:0];

endmodule

/* sv/ttr_index.sv */
// Destination and texel index arithmetic for one pixel copy.
// Depends on ttr_pkg for field widths.
module ttr_index #(
  parameter int RW = 11,
  parameter int FRAC_BITS = 8
) (
  input  logic [RW-1:0]               row_i,
  input  logic [ttr_pkg::EW-1:0]      x_i,
  input  logic [ttr_pkg::EW-1:0]      u_i,
  input  logic [ttr_pkg::EW-1:0]      v_i,
  input  logic [ttr_pkg::RGW-1:0]     tex_w_i,
  input  logic [ttr_pkg::RGW-1:0]     tgt_w_i,
  output logic [ttr_pkg::IW-1:0]      dst_o,
  output logic [ttr_pkg::IW-1:0]      src_o
);

  localparam int PW = RW + ttr_pkg::RGW;
  localparam int SW = ttr_pkg::IW + ttr_pkg::RGW;

  logic [ttr_pkg::EW-1:0] fx, fu, fv;
  logic [PW-1:0] pd;
  logic [SW-1:0] ps;

  // Floor of the fixed point values, then row pitch products
  always_comb begin
    fx = ttr_pkg::EW'($signed(x_i) >>> FRAC_BITS);
    fu = ttr_pkg::EW'($signed(u_i) >>> FRAC_BITS);
    fv = ttr_pkg::EW'($signed(v_i) >>> FRAC_BITS);
    pd = PW'(row_i) * PW'(tgt_w_i);
    ps = SW'(fv[ttr_pkg::IW-1:0]) * SW'(tex_w_i);
    dst_o = ttr_pkg::IW'(pd) + fx[ttr_pkg::IW-1:0];
    src_o = ps[ttr_pkg::IW-1:0] + fu[ttr_pkg::IW-1:0];
  end

endmodule
